// ===== hdl/kmv_pkg.sv =====
// Shared types and constants for the KMV distinct-count sketch.
package kmv_pkg;

    localparam int HASH_W = 64;
    localparam int CNT_W  = 9;
    localparam int CNT_MAX = (2 ** CNT_W) - 1;
    localparam int HASH_LAT = 6;

    localparam logic [HASH_W-1:0] MIX_ADD  = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [HASH_W-1:0] MIX_MUL1 = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [HASH_W-1:0] MIX_MUL2 = 64'h94d0_49bb_1331_11eb;

    typedef enum logic [1:0] {
        OUT_INSERTED  = 2'd0,
        OUT_DUPLICATE = 2'd1,
        OUT_REJECTED  = 2'd2,
        OUT_EVICTED   = 2'd3
    } t_outcome;

    // token walking down the cell row
    typedef struct packed {
        logic              vld;
        logic [HASH_W-1:0] val;      // value carried to the next cell
        logic              dup;      // equal entry found
        logic              swapped;  // hash went in, a larger entry is carried on
        logic              placed;   // carried value landed in the first free slot
        logic [HASH_W-1:0] largest;  // last occupied entry seen so far
    } t_tok;

    // sketch occupancy, broadcast to every cell
    typedef struct packed {
        logic [CNT_W-1:0] fill;
        logic [CNT_W-1:0] k_eff;
    } t_ctl;

endpackage

// ===== hdl/kmv_hash.sv =====
// Pipelined splitmix64 finaliser, 32x32 partial products per multiply.
module kmv_hash
    import kmv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [HASH_W-1:0] i_value,
    output logic              o_vld,
    output logic [HASH_W-1:0] o_hash
);

    logic [HASH_LAT-1:0] r_vld;
    logic [HASH_W-1:0]   r_add;
    logic [HASH_W-1:0]   r_pa0, r_pb0;
    logic [31:0]         r_pa1, r_pa2, r_pb1, r_pb2;
    logic [HASH_W-1:0]   r_m1, r_m2, r_hash;
    logic [HASH_W-1:0]   w_x1, w_x2;
    logic [31:0]         w_pa1, w_pa2, w_pb1, w_pb2;
    logic [31:0]         w_sa, w_sb;

    // cross terms only feed the upper word, so their low 32 bits suffice
    assign w_x1  = r_add ^ (r_add >> 30);
    assign w_pa1 = w_x1[31:0] * MIX_MUL1[63:32];
    assign w_pa2 = w_x1[63:32] * MIX_MUL1[31:0];
    assign w_sa  = r_pa1 + r_pa2;

    assign w_x2  = r_m1 ^ (r_m1 >> 27);
    assign w_pb1 = w_x2[31:0] * MIX_MUL2[63:32];
    assign w_pb2 = w_x2[63:32] * MIX_MUL2[31:0];
    assign w_sb  = r_pb1 + r_pb2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[HASH_LAT-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_add  <= i_value + MIX_ADD;
        r_pa0  <= {32'd0, w_x1[31:0]} * {32'd0, MIX_MUL1[31:0]};
        r_pa1  <= w_pa1;
        r_pa2  <= w_pa2;
        r_m1   <= r_pa0 + {w_sa, 32'd0};
        r_pb0  <= {32'd0, w_x2[31:0]} * {32'd0, MIX_MUL2[31:0]};
        r_pb1  <= w_pb1;
        r_pb2  <= w_pb2;
        r_m2   <= r_pb0 + {w_sb, 32'd0};
        r_hash <= r_m2 ^ (r_m2 >> 31);
    end

    assign o_vld  = r_vld[HASH_LAT-1];
    assign o_hash = r_hash;

endmodule

// ===== hdl/kmv_cell.sv =====
// One slot of the sorted hash row: compare, swap and pass the token on.
module kmv_cell
    import kmv_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_ctl i_ctl,
    input  t_tok i_tok,
    output t_tok o_tok
);

    localparam bit IN_RANGE = (IDX <= CNT_MAX);
    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic [HASH_W-1:0] r_slot, n_slot;
    t_tok              r_tok, n_tok;
    logic              w_used, w_free;

    assign w_used = IN_RANGE && (IDX_C < i_ctl.fill);
    assign w_free = IN_RANGE && (IDX_C == i_ctl.fill) && (IDX_C < i_ctl.k_eff);

    always_comb begin
        n_slot = r_slot;
        n_tok  = i_tok;
        if (i_tok.vld && !i_tok.dup && !i_tok.placed) begin
            if (w_used) begin
                if (i_tok.val == r_slot) begin
                    n_tok.dup = 1'b1;
                end else if (i_tok.val < r_slot) begin
                    n_slot        = i_tok.val;
                    n_tok.val     = r_slot;
                    n_tok.swapped = 1'b1;
                end
            end else if (w_free) begin
                n_slot       = i_tok.val;
                n_tok.placed = 1'b1;
            end
        end
        if (w_used || (w_free && n_tok.placed)) begin
            n_tok.largest = n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok.vld) begin
            r_slot <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== hdl/kmv_distinct_count_sketch_core.sv =====
// Top level of the KMV distinct-count sketch: control, APB register, cell row.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  input   | in        | i_valid / o_stall    | i_value
//  result  | out       | o_valid / i_stall    | o_outcome o_kept_count o_largest_kept
//          |           |                      | o_item_hash
//  config  | in        | psel penable pwrite  | paddr pwdata -> prdata, pready
//
// One item at a time: an accepted beat passes the hash pipeline, then its token walks
// one cell per cycle down the row of MAX_K cells, then come the result and output
// registers; the next beat is taken once the result has moved to the output register.
// Synchronous active-low reset empties the sketch (fill count to zero, k_limit 256);
// cell contents are left alone, cells at or above the fill count are never read.
// A result waiting on i_stall sits in the output register; the next beat is
// taken meanwhile, and a second finished result waits in a holding register,
// with the input stalled until the output register frees.
module kmv_distinct_count_sketch_core
    import kmv_pkg::*;
#(
    parameter int MAX_K = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input beats
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [HASH_W-1:0] i_value,
    // result beats
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [1:0]               o_outcome,
    output logic [CNT_W-1:0]         o_kept_count,
    output logic [HASH_W-1:0]        o_largest_kept,
    output logic [HASH_W-1:0]        o_item_hash,
    // register port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    localparam logic [CNT_W-1:0] K_RESET = CNT_W'(256);

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_k_limit, r_fill, n_fill;
    logic [CNT_W-1:0] w_k_eff, w_k_new;
    logic             w_acc, w_cfg_wr, w_out_free;

    // hash front end
    logic              w_h_vld;
    logic [HASH_W-1:0] w_h_val;
    logic [HASH_W-1:0] r_item_hash;

    // cell row
    t_tok w_tok [0:MAX_K];
    t_ctl w_ctl;

    // finished result waiting for the output register
    logic [1:0]        r_res_outcome;
    logic [CNT_W-1:0]  r_res_count;
    logic [HASH_W-1:0] r_res_largest;
    logic [HASH_W-1:0] r_res_hash;

    // output register
    logic              r_o_valid;
    logic [1:0]        r_o_outcome;
    logic [CNT_W-1:0]  r_o_count;
    logic [HASH_W-1:0] r_o_largest;
    logic [HASH_W-1:0] r_o_hash;

    // zero counts as one, anything past the row length saturates
    function automatic logic [CNT_W-1:0] eff_k(input logic [CNT_W-1:0] k);
        logic [CNT_W-1:0] r;
        r = k;
        if (k == '0) begin
            r = CNT_W'(1);
        end else if (int'(k) > MAX_K) begin
            r = CNT_W'(MAX_K);
        end
        return r;
    endfunction

    assign w_k_eff  = eff_k(r_k_limit);
    assign w_k_new  = eff_k(pwdata[CNT_W-1:0]);
    assign w_cfg_wr = psel && penable && pwrite && !paddr[2];
    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? 32'd0 : {{(32 - CNT_W){1'b0}}, r_k_limit};

    assign o_stall    = (r_state != ST_IDLE);
    assign w_acc      = i_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_o_valid || !i_stall;

    kmv_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_acc),
        .i_value (i_value),
        .o_vld   (w_h_vld),
        .o_hash  (w_h_val)
    );

    // fresh hash enters the head of the row
    always_comb begin
        w_tok[0]         = '0;
        w_tok[0].vld     = w_h_vld;
        w_tok[0].val     = w_h_val;
    end

    assign w_ctl.fill  = r_fill;
    assign w_ctl.k_eff = w_k_eff;

    for (genvar g = 0; g < MAX_K; g++) begin : g_cell
        kmv_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) n_state = ST_BUSY;
            end
            ST_BUSY: begin
                if (w_tok[MAX_K].vld) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // fill count: grows on a placed token, cut down by a smaller limit
    always_comb begin
        n_fill = r_fill;
        if (w_cfg_wr) begin
            if (r_fill > w_k_new) n_fill = w_k_new;
        end else if (r_state == ST_BUSY && w_tok[MAX_K].vld && w_tok[MAX_K].placed) begin
            n_fill = r_fill + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_k_limit <= K_RESET;
            r_fill    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (w_cfg_wr) r_k_limit <= pwdata[CNT_W-1:0];
            if (r_state == ST_DONE && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_h_vld) r_item_hash <= w_h_val;
        if (r_state == ST_BUSY && w_tok[MAX_K].vld) begin
            r_res_hash    <= r_item_hash;
            r_res_largest <= w_tok[MAX_K].largest;
            r_res_count   <= n_fill;
            if (w_tok[MAX_K].dup) begin
                r_res_outcome <= OUT_DUPLICATE;
            end else if (w_tok[MAX_K].placed) begin
                r_res_outcome <= OUT_INSERTED;
            end else if (w_tok[MAX_K].swapped) begin
                r_res_outcome <= OUT_EVICTED;
            end else begin
                r_res_outcome <= OUT_REJECTED;
            end
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_o_outcome <= r_res_outcome;
            r_o_count   <= r_res_count;
            r_o_largest <= r_res_largest;
            r_o_hash    <= r_res_hash;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_outcome      = r_o_outcome;
    assign o_kept_count   = r_o_count;
    assign o_largest_kept = r_o_largest;
    assign o_item_hash    = r_o_hash;

endmodule

// ===== dv/kmv_sketch_checker.sv =====
// Checker for the KMV sketch core: follows k_limit writes, predicts each result beat, compares.
module kmv_sketch_checker
    import kmv_pkg::*;
#(
    parameter int         MAX_K        = 256,
    parameter logic [2:0] K_LIMIT_ADDR = 3'd0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    input  logic              i_item_stall,
    input  logic [HASH_W-1:0] i_item_value,
    input  logic              i_res_valid,
    input  logic              i_res_stall,
    input  logic [1:0]        i_res_outcome,
    input  logic [CNT_W-1:0]  i_res_kept_count,
    input  logic [HASH_W-1:0] i_res_largest_kept,
    input  logic [HASH_W-1:0] i_res_item_hash,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [2:0]        i_paddr,
    input  logic [31:0]       i_pwdata,
    output int                o_pending,
    output int                o_fail_count,
    output int                o_checked
);

    typedef struct packed {
        t_outcome          outcome;
        logic [CNT_W-1:0]  kept;
        logic [HASH_W-1:0] largest;
        logic [HASH_W-1:0] hash;
    } t_sketch_beat;

    // predicted sketch contents, ascending in 0 .. kept_fill-1
    logic [HASH_W-1:0] kept_hash [MAX_K];
    int                kept_fill = 0;
    logic [CNT_W-1:0]  k_reg     = 9'd256;

    t_sketch_beat result_q [$];
    int           fail_n    = 0;
    int           checked_n = 0;
    int           pending_n = 0;

    assign o_pending    = pending_n;
    assign o_fail_count = fail_n;
    assign o_checked    = checked_n;

    function automatic logic [HASH_W-1:0] splitmix_hash(input logic [HASH_W-1:0] v);
        logic [HASH_W-1:0] h;
        h = v + MIX_ADD;
        h = (h ^ (h >> 30)) * MIX_MUL1;
        h = (h ^ (h >> 27)) * MIX_MUL2;
        return h ^ (h >> 31);
    endfunction

    // zero means one, anything above MAX_K saturates
    function automatic int k_effective(input logic [CNT_W-1:0] k);
        if (k == '0)
            return 1;
        if (int'(k) > MAX_K)
            return MAX_K;
        return int'(k);
    endfunction

    function automatic t_sketch_beat sketch_absorb(input logic [HASH_W-1:0] v);
        t_sketch_beat      r;
        logic [HASH_W-1:0] h;
        int                k;
        int                pos;
        int                i;
        h   = splitmix_hash(v);
        k   = k_effective(k_reg);
        pos = 0;
        if (kept_fill > k)
            kept_fill = k;
        while (pos < kept_fill && kept_hash[pos] < h)
            pos++;
        if (pos < kept_fill && kept_hash[pos] == h) begin
            r.outcome = OUT_DUPLICATE;
        end else if (kept_fill < k) begin
            for (i = kept_fill; i > pos; i--)
                kept_hash[i] = kept_hash[i-1];
            kept_hash[pos] = h;
            kept_fill++;
            r.outcome = OUT_INSERTED;
        end else if (pos >= kept_fill) begin
            r.outcome = OUT_REJECTED;
        end else begin
            // largest drops off the end
            for (i = kept_fill - 1; i > pos; i--)
                kept_hash[i] = kept_hash[i-1];
            kept_hash[pos] = h;
            r.outcome = OUT_EVICTED;
        end
        r.kept    = CNT_W'(kept_fill);
        r.largest = (kept_fill > 0) ? kept_hash[kept_fill-1] : '0;
        r.hash    = h;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_sketch_beat want;
        if (!i_rst_n) begin
            kept_fill = 0;
            k_reg     = 9'd256;
            result_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == K_LIMIT_ADDR) begin
                k_reg = i_pwdata[CNT_W-1:0];
                if (kept_fill > k_effective(k_reg))
                    kept_fill = k_effective(k_reg);
            end
            if (i_item_valid && !i_item_stall)
                result_q.push_back(sketch_absorb(i_item_value));
            if (i_res_valid && !i_res_stall) begin
                if (result_q.size() == 0) begin
                    $error("result beat with nothing outstanding: outcome %0d, hash %h",
                           i_res_outcome, i_res_item_hash);
                    fail_n++;
                end else begin
                    want = result_q.pop_front();
                    if (i_res_outcome !== 2'(want.outcome)) begin
                        $error("outcome: expected %0d, got %0d", want.outcome, i_res_outcome);
                        fail_n++;
                    end
                    if (i_res_kept_count !== want.kept) begin
                        $error("kept_count: expected %0d, got %0d", want.kept,
                               i_res_kept_count);
                        fail_n++;
                    end
                    if (i_res_largest_kept !== want.largest) begin
                        $error("largest_kept: expected %h, got %h", want.largest,
                               i_res_largest_kept);
                        fail_n++;
                    end
                    if (i_res_item_hash !== want.hash) begin
                        $error("item_hash: expected %h, got %h", want.hash, i_res_item_hash);
                        fail_n++;
                    end
                    checked_n++;
                end
            end
        end
        pending_n = result_q.size();
    end

endmodule

// ===== dv/tb_kmv_distinct_count_sketch_core.sv =====
// Testbench top for the KMV sketch core: clock, reset, beats, k_limit writes and verdict.
module tb_kmv_distinct_count_sketch_core
    import kmv_pkg::*;
();

    localparam int         MAX_K        = 256;
    localparam logic [2:0] K_LIMIT_ADDR = 3'd0;  // register 0
    localparam logic [2:0] SPARE_ADDR   = 3'd4;  // index 1, nothing decoded there
    localparam int         MAX_WAIT     = 13;    // longest random gap or stall per beat
    localparam int         LONG_HOLD    = 2000;  // receiver hold-off, backs up the input
    localparam int         DRAIN_CYCLES = MAX_K + 40;
    localparam int         POOL_N       = 64;    // recent values, source of repeats

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic signed [HASH_W-1:0] i_value;
    logic                     o_valid;
    logic                     i_stall;
    logic [1:0]               o_outcome;
    logic [CNT_W-1:0]         o_kept_count;
    logic [HASH_W-1:0]        o_largest_kept;
    logic [HASH_W-1:0]        o_item_hash;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [2:0]               paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    int pending;
    int fail_count;
    int checked;

    // run bookkeeping; initialised here as both processes read them from time zero
    int                values_sent   = 0;
    int                settings_done = 0;
    int                hold_asks     = 0;
    int                hold_done     = 0;
    bit                send_calm     = 1'b0;
    bit                recv_calm     = 1'b0;
    logic [HASH_W-1:0] value_pool [POOL_N];

    kmv_distinct_count_sketch_core #(
        .MAX_K(MAX_K)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_outcome     (o_outcome),
        .o_kept_count  (o_kept_count),
        .o_largest_kept(o_largest_kept),
        .o_item_hash   (o_item_hash),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    kmv_sketch_checker #(
        .MAX_K       (MAX_K),
        .K_LIMIT_ADDR(K_LIMIT_ADDR)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item_valid      (i_valid),
        .i_item_stall      (o_stall),
        .i_item_value      (i_value),
        .i_res_valid       (o_valid),
        .i_res_stall       (i_stall),
        .i_res_outcome     (o_outcome),
        .i_res_kept_count  (o_kept_count),
        .i_res_largest_kept(o_largest_kept),
        .i_res_item_hash   (o_item_hash),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_pready          (pready),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .o_pending         (pending),
        .o_fail_count      (fail_count),
        .o_checked         (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop, several times the slowest legal run: ~860 beats, each one
    // walking the full cell row plus worst gap and stall, and two long hold-offs.
    initial begin
        #12_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Offer one beat after a random gap; returns at the edge that takes it.
    // In calm stretches the gap is zero, so each beat is offered as soon as the last is taken.
    task automatic send_value(input logic [HASH_W-1:0] v);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        values_sent++;
        if ($urandom_range(0, 39) == 0)
            send_calm = !send_calm;
    endtask

    // Setup then access phase; the upper data bits carry junk the block must mask.
    task automatic apb_write(input logic [2:0] addr, input logic [CNT_W-1:0] k);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= ($urandom & 32'hFFFF_FE00) | 32'(k);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == K_LIMIT_ADDR)
            settings_done++;
    endtask

    // Register writes only happen with nothing in flight.
    task automatic wait_idle();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Repeats from a rolling pool (duplicates, re-rejections) or, at fresh_pct percent,
    // fresh 64-bit values, now and then one of the field extremes.
    function automatic logic [HASH_W-1:0] pick_value(input int fresh_pct);
        logic [HASH_W-1:0] v;
        int                slot;
        slot = $urandom_range(0, POOL_N - 1);
        if ($urandom_range(0, 49) == 0) begin
            case ($urandom_range(0, 3))
                0:       v = '0;
                1:       v = '1;
                2:       v = {1'b1, {(HASH_W-1){1'b0}}};
                default: v = {1'b0, {(HASH_W-1){1'b1}}};
            endcase
        end else if ($urandom_range(0, 99) < fresh_pct) begin
            v = {$urandom, $urandom};
            value_pool[slot] = v;
        end else begin
            v = value_pool[slot];
        end
        return v;
    endfunction

    // One random phase: set k_limit, then a run of beats. hold_at picks the
    // beat at which the receiver is asked for its long hold-off (-1: none).
    task automatic run_phase(input logic [CNT_W-1:0] k, input int count,
                             input int fresh_pct, input int hold_at);
        int n;
        wait_idle();
        apb_write(K_LIMIT_ADDR, k);
        for (n = 0; n < count; n++) begin
            if (n == hold_at)
                hold_asks++;
            send_value(pick_value(fresh_pct));
        end
        i_valid <= 1'b0;
    endtask

    // Receiver: random stall before each beat, calm stretches with none, and
    // the long hold-off on request, counted here so the sender keeps pushing.
    initial begin
        int stall_len;
        i_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_done < hold_asks) begin
                stall_len = LONG_HOLD;
                hold_done++;
            end else begin
                stall_len = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (stall_len > 0) begin
                i_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            if ($urandom_range(0, 29) == 0)
                recv_calm = !recv_calm;
        end
    end

    initial begin
        int n;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_value <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        for (n = 0; n < POOL_N; n++)
            value_pool[n] = {$urandom, $urandom};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, k_limit at its reset value 256: field extremes, then
        // repeats of a kept value, the smallest and the largest alike.
        send_value('0);
        send_value('1);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'h7FFF_FFFF_FFFF_FFFF);
        send_value(64'd1);
        send_value('0);
        send_value(64'h7FFF_FFFF_FFFF_FFFF);
        send_value(64'h5555_5555_5555_5555);
        send_value(64'hAAAA_AAAA_AAAA_AAAA);
        send_value(64'h0123_4567_89AB_CDEF);
        i_valid <= 1'b0;

        // Write to an index with no register: must change nothing.
        wait_idle();
        apb_write(SPARE_ADDR, 9'd1);
        @(posedge i_clk);
        // Lower k_limit under the fill: the sketch is cut to its three smallest.
        apb_write(K_LIMIT_ADDR, 9'd3);

        // Full sketch of three: a run of new values gives rejections and
        // evictions, old ones give duplicates or repeat rejections.
        for (n = 2; n < 10; n++)
            send_value(64'(n));
        send_value(64'h8000_0000_0000_0000);
        send_value('1);
        send_value('0);
        send_value(64'hFEDC_BA98_7654_3210);
        send_value('0);
        i_valid <= 1'b0;

        // Random phases: full-size sketch up to kept_count 256, a cut to seven,
        // zero read as one, 511 saturated to MAX_K, a mid size, and one again.
        run_phase(9'd256, 300, 80, 120);
        run_phase(9'd7,   120, 50, -1);
        run_phase(9'd0,    60, 40, -1);
        run_phase(9'd511, 150, 70, -1);
        run_phase(9'd32,  150, 40, 60);
        run_phase(9'd1,    50, 30, -1);

        wait_idle();
        // anything late or unexpected still shows up in the checker
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d values over %0d k_limit settings, %0d results compared",
                 values_sent, settings_done, checked);
        $display("Summary: %0d receiver hold-offs of %0d cycles backed the input up",
                 hold_done, LONG_HOLD);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
